### hw/rtl/idiv_pkg.sv
// Shared types and constants for the pipelined integer divider.
// Used by idiv_prep, idiv_cell, idiv_post and integer_divider_32_64.
`default_nettype none

package idiv_pkg;

    // Operand and result widths.
    localparam int HALF_W = 32;
    localparam int FULL_W = 2 * HALF_W;

    // One cell per quotient bit of the full-width division.
    localparam int NUM_CELLS = FULL_W;

    // Request type codes. Code 3 is decoded by its high bit and acts as the wide mode.
    typedef enum logic [1:0] {
        REQ_SIGNED32   = 2'd0,
        REQ_UNSIGNED32 = 2'd1,
        REQ_UNSIGNED64 = 2'd2,
        REQ_UNSIGNED64_ALT = 2'd3
    } t_req_type;

    // Request payload.
    typedef struct packed {
        logic [1:0]        req_type;
        logic [HALF_W-1:0] dividend_low;
        logic [HALF_W-1:0] dividend_high;
        logic [HALF_W-1:0] denom_low;
        logic [HALF_W-1:0] denom_high;
    } t_req;

    // Result payload.
    typedef struct packed {
        logic [HALF_W-1:0] quotient;
        logic [HALF_W-1:0] remainder;
        logic              divide_by_zero;
    } t_rsp;

    // Data that travels from one cell to the next.
    typedef struct packed {
        logic              neg_q;   // negate quotient at the end
        logic              neg_r;   // negate remainder at the end
        logic              dz;      // divisor was zero
        logic              wide;    // 64-bit request, remainder forced to zero
        logic [FULL_W-1:0] dvd;     // dividend bits, quotient bits shift in at the bottom
        logic [FULL_W-1:0] rem;     // partial remainder
        logic [FULL_W-1:0] dsr;     // divisor magnitude
    } t_cell;

endpackage

`default_nettype wire

### hw/rtl/integer_divider_32_64.sv
// Top level of the pipelined integer divider: input stage, a row of 64 cells, output stage.
// Depends on idiv_pkg, idiv_prep, idiv_cell and idiv_post.
//
//  Port group        Direction  Meaning
//  start, i_req      in         division request, taken when start is high and busy low
//  busy              out        always low, a request is taken every cycle
//  o_done, o_rsp     out        one result, shown for exactly one cycle
//
// A request is taken in any cycle; its result passes through one input stage,
// 64 cells of one quotient bit each, and one output stage.
// The pipeline never stalls; throughput is one request per cycle.
// Results come out in request order and cannot be held off by the receiver.
// Synchronous active-low reset clears all valid flags in the pipeline.
`default_nettype none

module integer_divider_32_64
    import idiv_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_req i_req,
    output logic      busy,
    output logic      o_done,
    output t_rsp      o_rsp
);

    logic  cell_valid [NUM_CELLS+1];
    t_cell cell_data  [NUM_CELLS+1];

    // The pipeline never stalls.
    assign busy = 1'b0;

    // Operand decode into the first cell.
    idiv_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_req   (i_req),
        .o_valid (cell_valid[0]),
        .o_cell  (cell_data[0])
    );

    // Row of division cells, one quotient bit each.
    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        idiv_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (cell_valid[g]),
            .i_cell  (cell_data[g]),
            .o_valid (cell_valid[g+1]),
            .o_cell  (cell_data[g+1])
        );
    end

    // Sign fix-up and result register.
    idiv_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cell_valid[NUM_CELLS]),
        .i_cell  (cell_data[NUM_CELLS]),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

endmodule

`default_nettype wire

### hw/rtl/idiv_prep.sv
// Input stage of the divider: decodes the request into unsigned magnitudes.
// Depends on idiv_pkg.
`default_nettype none

module idiv_prep
    import idiv_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_req  i_req,
    output logic       o_valid,
    output t_cell      o_cell
);

    logic        r_valid;
    t_cell       r_cell;
    t_cell       n_cell;
    logic        nneg;
    logic        dneg;
    logic [HALF_W-1:0] mag_n;
    logic [HALF_W-1:0] mag_d;

    // Magnitudes of the 32-bit operands in signed mode.
    always_comb begin
        nneg  = (i_req.req_type == REQ_SIGNED32) && i_req.dividend_low[HALF_W-1];
        dneg  = (i_req.req_type == REQ_SIGNED32) && i_req.denom_low[HALF_W-1];
        mag_n = nneg ? (~i_req.dividend_low + HALF_W'(1)) : i_req.dividend_low;
        mag_d = dneg ? (~i_req.denom_low + HALF_W'(1)) : i_req.denom_low;
    end

    // Build the first cell's operands; 32-bit modes run zero-extended.
    always_comb begin
        n_cell     = '0;
        n_cell.rem = '0;
        if (i_req.req_type[1]) begin
            n_cell.wide  = 1'b1;
            n_cell.dvd   = {i_req.dividend_high, i_req.dividend_low};
            n_cell.dsr   = {i_req.denom_high, i_req.denom_low};
            n_cell.dz    = ({i_req.denom_high, i_req.denom_low} == '0);
        end else begin
            n_cell.wide  = 1'b0;
            n_cell.dvd   = {{HALF_W{1'b0}}, mag_n};
            n_cell.dsr   = {{HALF_W{1'b0}}, mag_d};
            n_cell.dz    = (i_req.denom_low == '0);
            n_cell.neg_q = nneg ^ dneg;
            n_cell.neg_r = nneg;
        end
    end

    // Valid flag with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // Operand register.
    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
    end

    assign o_valid = r_valid;
    assign o_cell  = r_cell;

endmodule

`default_nettype wire

### hw/rtl/idiv_cell.sv
// One restoring-division cell: produces one quotient bit and passes the operands on.
// Depends on idiv_pkg.
`default_nettype none

module idiv_cell
    import idiv_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_cell i_cell,
    output logic       o_valid,
    output t_cell      o_cell
);

    logic              r_valid;
    t_cell             r_cell;
    t_cell             n_cell;
    logic [FULL_W:0]   trial;
    logic [FULL_W+1:0] diff;
    logic              qbit;

    // Shift the next dividend bit into the remainder and try to subtract.
    always_comb begin
        trial  = {i_cell.rem, i_cell.dvd[FULL_W-1]};
        diff   = {1'b0, trial} - {2'b00, i_cell.dsr};
        qbit   = !diff[FULL_W+1];
        n_cell = i_cell;
        n_cell.dvd = {i_cell.dvd[FULL_W-2:0], qbit};
        n_cell.rem = qbit ? diff[FULL_W-1:0] : trial[FULL_W-1:0];
    end

    // Valid flag with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // Payload register.
    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
    end

    assign o_valid = r_valid;
    assign o_cell  = r_cell;

endmodule

`default_nettype wire

### hw/rtl/idiv_post.sv
// Output stage of the divider: applies signs, zero-divisor and wide-mode rules.
// Depends on idiv_pkg.
`default_nettype none

module idiv_post
    import idiv_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_cell i_cell,
    output logic       o_done,
    output t_rsp       o_rsp
);

    logic              r_done;
    t_rsp              r_rsp;
    t_rsp              n_rsp;
    logic [HALF_W-1:0] q_lo;
    logic [HALF_W-1:0] r_lo;

    // Sign correction and forced-zero cases.
    always_comb begin
        q_lo = i_cell.dvd[HALF_W-1:0];
        r_lo = i_cell.rem[HALF_W-1:0];
        n_rsp.divide_by_zero = i_cell.dz;
        if (i_cell.dz) begin
            n_rsp.quotient = '0;
        end else if (i_cell.neg_q) begin
            n_rsp.quotient = ~q_lo + HALF_W'(1);
        end else begin
            n_rsp.quotient = q_lo;
        end
        if (i_cell.dz || i_cell.wide) begin
            n_rsp.remainder = '0;
        end else if (i_cell.neg_r) begin
            n_rsp.remainder = ~r_lo + HALF_W'(1);
        end else begin
            n_rsp.remainder = r_lo;
        end
    end

    // Result strobe with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_valid;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

`default_nettype wire

### tb/divider_checker.sv
// Result checker for integer_divider_32_64: predicts each division at request time.
// Compares every result strobe with the oldest prediction. Depends on idiv_pkg.
`timescale 1ns / 100ps

module divider_checker
    import idiv_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire logic i_busy,
    input  wire t_req i_req,
    input  wire logic i_done,
    input  wire t_rsp i_rsp,
    output int        o_failures,
    output int        o_pending
);

    // Predictions for requests whose results have not come out yet, oldest first.
    t_rsp due_results[$];
    int   failures = 0;
    int   pending_count = 0;

    assign o_failures = failures;
    assign o_pending  = pending_count;

    // Quotient, remainder and divide-by-zero flag for one request.
    function automatic t_rsp compute_division(input t_req rq);
        logic [63:0] num;
        logic [63:0] den;
        logic [31:0] n_mag;
        logic [31:0] d_mag;
        logic [31:0] q_mag;
        logic [31:0] r_mag;
        logic        n_neg;
        logic        d_neg;
        t_rsp        rs;
        rs = '0;
        num = {rq.dividend_high, rq.dividend_low};
        den = {rq.denom_high, rq.denom_low};
        // Both wide codes share the high bit of the request type.
        if (rq.req_type[1]) begin
            if (den == 64'd0) begin
                rs.divide_by_zero = 1'b1;
            end else begin
                num = num / den;
                rs.quotient = num[31:0];
            end
        end else if (rq.denom_low == 32'd0) begin
            rs.divide_by_zero = 1'b1;
        end else if (rq.req_type == REQ_UNSIGNED32) begin
            rs.quotient  = rq.dividend_low / rq.denom_low;
            rs.remainder = rq.dividend_low % rq.denom_low;
        end else begin
            // Divide magnitudes, then restore signs. The most negative value
            // by minus one wraps back to the dividend without special handling.
            n_neg = rq.dividend_low[31];
            d_neg = rq.denom_low[31];
            n_mag = n_neg ? 32'd0 - rq.dividend_low : rq.dividend_low;
            d_mag = d_neg ? 32'd0 - rq.denom_low : rq.denom_low;
            q_mag = n_mag / d_mag;
            r_mag = n_mag % d_mag;
            rs.quotient  = (n_neg != d_neg) ? 32'd0 - q_mag : q_mag;
            rs.remainder = n_neg ? 32'd0 - r_mag : r_mag;
        end
        return rs;
    endfunction

    // Record predictions on accepted requests and check each result strobe.
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n) begin
            if (i_start && !i_busy) begin
                due_results.push_back(compute_division(i_req));
            end
            if (i_done) begin
                if (due_results.size() == 0) begin
                    $error("result strobe with no request outstanding");
                    failures++;
                end else begin
                    want = due_results.pop_front();
                    if (i_rsp.quotient !== want.quotient) begin
                        $error("quotient: expected %h, got %h", want.quotient, i_rsp.quotient);
                        failures++;
                    end
                    if (i_rsp.remainder !== want.remainder) begin
                        $error("remainder: expected %h, got %h",
                               want.remainder, i_rsp.remainder);
                        failures++;
                    end
                    if (i_rsp.divide_by_zero !== want.divide_by_zero) begin
                        $error("divide_by_zero: expected %b, got %b",
                               want.divide_by_zero, i_rsp.divide_by_zero);
                        failures++;
                    end
                end
            end
            pending_count <= due_results.size();
        end
    end

endmodule

### tb/tb.sv
// Testbench top for integer_divider_32_64: clock, reset, request stimulus and verdict.
// Depends on idiv_pkg, integer_divider_32_64 and divider_checker.
`timescale 1ns / 100ps

module tb
    import idiv_pkg::*;
();

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 80;
    localparam int RANDOM_PHASES = 4;
    localparam int PHASE_ITEMS   = 325;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    t_req i_req;
    logic busy;
    logic o_done;
    t_rsp o_rsp;
    int   failures;
    int   pending;
    int   cycle_count = 0;

    // Percent of cycles the requester stays idle in each random phase.
    int   idle_by_phase[RANDOM_PHASES] = '{0, 46, 0, 35};

    always #4 i_clk = ~i_clk;

    integer_divider_32_64 uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    divider_checker checker_inst (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_busy     (busy),
        .i_req      (i_req),
        .i_done     (o_done),
        .i_rsp      (o_rsp),
        .o_failures (failures),
        .o_pending  (pending)
    );

    // Give up if the run hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic t_req make_request(input t_req_type kind, input logic [31:0] n_lo,
                                          input logic [31:0] n_hi, input logic [31:0] d_lo,
                                          input logic [31:0] d_hi);
        t_req rq;
        rq.req_type      = kind;
        rq.dividend_low  = n_lo;
        rq.dividend_high = n_hi;
        rq.denom_low     = d_lo;
        rq.denom_high    = d_hi;
        return rq;
    endfunction

    // Operand word biased toward zero, edge values and short magnitudes.
    function automatic logic [31:0] shaped_word();
        case ($urandom_range(7))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'($urandom_range(16));
            4, 5: return $urandom >> $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_req random_request();
        t_req rq;
        rq.req_type      = 2'($urandom_range(3));
        rq.dividend_low  = shaped_word();
        rq.dividend_high = shaped_word();
        rq.denom_low     = shaped_word();
        // Wide divisors often fit in the low half so quotients stay interesting.
        rq.denom_high    = ($urandom_range(2) == 0) ? shaped_word() : $urandom;
        if (!rq.req_type[1] || $urandom_range(3) != 0) begin
            rq.denom_high = ($urandom_range(1) == 0) ? 32'd0 : rq.denom_high;
        end
        return rq;
    endfunction

    // Present one request after a random idle gap and hold it until it is taken.
    task automatic send_request(input t_req rq, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= rq;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Hold off new requests until every outstanding result has come out.
    task automatic wait_all_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        start   <= 1'b0;
        i_req   <= '0;
        i_rst_n <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Signed mode: every sign combination, wrap case, zero divisor.
        send_request(make_request(REQ_SIGNED32, 32'd7, 32'd0, 32'd2, 32'd0), 0);
        send_request(make_request(REQ_SIGNED32, -32'sd7, 32'd0, 32'd2, 32'd0), 0);
        send_request(make_request(REQ_SIGNED32, 32'd7, 32'd0, -32'sd2, 32'd0), 0);
        send_request(make_request(REQ_SIGNED32, -32'sd7, 32'd0, -32'sd2, 32'd0), 0);
        send_request(make_request(REQ_SIGNED32, 32'h8000_0000, 32'hFFFF_FFFF,
                                  32'hFFFF_FFFF, 32'hFFFF_FFFF), 0);
        send_request(make_request(REQ_SIGNED32, 32'h8000_0000, 32'd0, 32'd1, 32'd0), 0);
        send_request(make_request(REQ_SIGNED32, 32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd0), 0);
        send_request(make_request(REQ_SIGNED32, 32'h1234_5678, 32'd0, 32'd0, 32'hFFFF_FFFF), 0);
        send_request(make_request(REQ_SIGNED32, 32'hFFFF_FFFF, 32'd0, 32'h8000_0000, 32'd0), 0);

        // Unsigned 32-bit mode; the high halves must be ignored.
        send_request(make_request(REQ_UNSIGNED32, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd0), 0);
        send_request(make_request(REQ_UNSIGNED32, 32'hFFFF_FFFF, 32'd0,
                                  32'hFFFF_FFFF, 32'd0), 0);
        send_request(make_request(REQ_UNSIGNED32, 32'd5, 32'hFFFF_FFFF, 32'd0,
                                  32'hFFFF_FFFF), 0);
        send_request(make_request(REQ_UNSIGNED32, 32'd0, 32'd0, 32'd7, 32'd0), 0);
        send_request(make_request(REQ_UNSIGNED32, 32'd123456789, 32'hFFFF_FFFF, 32'd1000,
                                  32'hFFFF_FFFF), 0);

        // Unsigned 64-bit mode, including a divisor whose low half alone is zero.
        send_request(make_request(REQ_UNSIGNED64, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd0), 0);
        send_request(make_request(REQ_UNSIGNED64, 32'd0, 32'd1, 32'd1, 32'd0), 0);
        send_request(make_request(REQ_UNSIGNED64, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                  32'hFFFF_FFFF, 32'hFFFF_FFFF), 0);
        send_request(make_request(REQ_UNSIGNED64, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                  32'd0, 32'd1), 0);
        send_request(make_request(REQ_UNSIGNED64, 32'd9, 32'd9, 32'd0, 32'd0), 0);
        send_request(make_request(REQ_UNSIGNED64, 32'd5, 32'd0, 32'd7, 32'd3), 0);

        // The unused code behaves as the wide mode.
        send_request(make_request(REQ_UNSIGNED64_ALT, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                  32'd3, 32'd0), 0);
        send_request(make_request(REQ_UNSIGNED64_ALT, 32'd1, 32'd2, 32'd0, 32'd0), 0);
        send_request(make_request(REQ_UNSIGNED64_ALT, 32'd0, 32'h8000_0000, 32'd0, 32'd1), 0);

        // Random requests in phases of differing requester idleness.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_all_results();
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                send_request(random_request(), idle_by_phase[ph]);
            end
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failures == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/idiv_pkg.sv
hw/rtl/idiv_prep.sv
hw/rtl/idiv_cell.sv
hw/rtl/idiv_post.sv
hw/rtl/integer_divider_32_64.sv
tb/divider_checker.sv
tb/tb.sv
